### rtl/vnt3_pkg.sv
// Package for the trilinear value noise core: constants, op codes, types.
// No dependencies.
`default_nettype none
package vnt3_pkg;
    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int VAL_W      = 16;
    localparam int OP_W       = 3;
    localparam int ENTRY_IDX_W = 8;
    localparam int ENTRY_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY   = 3'd0,
        OP_WR_VAL  = 3'd1,
        OP_WR_PX   = 3'd2,
        OP_WR_PY   = 3'd3,
        OP_WR_PZ   = 3'd4
    } op_t;
endpackage
`default_nettype wire

### rtl/vnt3_perm.sv
// Permutation tables for x, y, z plus corner index formation.
// Depends on vnt3_pkg. Registered reads, two reads per table per cycle while en is high.
`default_nettype none
module vnt3_perm #(
    parameter int TABLE_SIZE = vnt3_pkg::TABLE_SIZE,
    parameter int IW = $clog2(TABLE_SIZE)
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [2:0]    wr_sel,   // one-hot: x, y, z
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [IW-1:0] wr_data,
    input  wire logic [IW-1:0] ix,
    input  wire logic [IW-1:0] iy,
    input  wire logic [IW-1:0] iz,
    output logic [IW-1:0]      px_reg [2],
    output logic [IW-1:0]      py_reg [2],
    output logic [IW-1:0]      pz_reg [2]
);
    logic [IW-1:0] mem_x [TABLE_SIZE];
    logic [IW-1:0] mem_y [TABLE_SIZE];
    logic [IW-1:0] mem_z [TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (wr_sel[0]) mem_x[wr_idx] <= wr_data;
        if (wr_sel[1]) mem_y[wr_idx] <= wr_data;
        if (wr_sel[2]) mem_z[wr_idx] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= mem_x[ix];
            px_reg[1] <= mem_x[ix + IW'(1)];
            py_reg[0] <= mem_y[iy];
            py_reg[1] <= mem_y[iy + IW'(1)];
            pz_reg[0] <= mem_z[iz];
            pz_reg[1] <= mem_z[iz + IW'(1)];
        end
    end
endmodule
`default_nettype wire

### rtl/vnt3_lerp.sv
// One linear blend stage: a*(1-t) + b*t, registered.
// Depends on nothing but its parameters.
`default_nettype none
module vnt3_lerp #(
    parameter int IN_W = 16,
    parameter int FB   = 16
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [IN_W-1:0]    a,
    input  wire logic [IN_W-1:0]    b,
    input  wire logic [FB-1:0]      t,
    output logic [IN_W+FB-1:0]      y_reg
);
    // a + (b - a)*t scaled: a*2^FB + (b-a)*t, exact and non-negative
    logic signed [IN_W:0]       diff;
    logic signed [IN_W+FB+1:0]  sum;
    assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
    assign sum  = $signed({2'b00, a, {FB{1'b0}}}) + diff * $signed({1'b0, t});

    always_ff @(posedge aclk) begin
        if (en) y_reg <= sum[IN_W+FB-1:0];
    end
endmodule
`default_nettype wire

### rtl/value_noise_trilinear_3d_core.sv
// Top level of the trilinear value noise core.
// Depends on vnt3_pkg, vnt3_perm, vnt3_lerp.
//
// Usage:
//  - Slave channel carries queries and table writes; s_axis_tuser holds op.
//    tdata, from bit 0: coord_x[31:0], coord_y[31:0], coord_z[31:0],
//    entry_index[7:0], entry_data[15:0] (120 bits).
//  - Master channel carries one noise value per query; writes give none.
//  - Pipeline of seven stages: stage 1 registers the item and splits cells
//    and fractions, stage 2 reads the three permutation tables, stage 3
//    forms the corner keys, stage 4 reads the value table (eight reads),
//    stages 5 to 7 blend along z, y and x.
//  - Throughput: one item per cycle. The whole pipeline advances together;
//    when the receiver stalls with a result waiting, every stage holds and
//    s_axis_tready drops, so nothing is lost or repeated.
//  - Permutation writes land at the slave transfer; value writes travel
//    down to stage 4 and land there, so every query sees exactly the writes
//    sent before it. Tables are not cleared at reset; load every entry
//    before use.
//  - Reset clears all valid bits only.
`default_nettype none
module value_noise_trilinear_3d_core #(
    parameter int TABLE_SIZE = vnt3_pkg::TABLE_SIZE,
    parameter int FRAC_BITS  = vnt3_pkg::FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coord_x, coord_y, coord_z, entry_index, entry_data (low bit up)
    input  wire logic [119:0] s_axis_tdata,
    // op
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // noise
    output logic [15:0]       m_axis_tdata
);
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int VW = vnt3_pkg::VAL_W;
    localparam int FB = FRAC_BITS;
    localparam int NS = 7;

    // advance whole pipe unless the output holds an untaken result
    logic en;
    logic [NS-1:0] vld_reg;
    logic [2:0]    vwr_reg;
    logic          vwr;
    assign en = !(vld_reg[NS-1] && !m_axis_tready);
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vwr_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0],
                        s_axis_tvalid && (s_axis_tuser == vnt3_pkg::OP_QUERY)};
            vwr_reg <= {vwr_reg[1:0], vwr};
        end
    end

    // stage 1: split input
    logic [31:0] cx, cy, cz;
    logic [7:0]  e_idx;
    logic [15:0] e_data;
    assign cx = s_axis_tdata[31:0];
    assign cy = s_axis_tdata[63:32];
    assign cz = s_axis_tdata[95:64];
    assign e_idx = s_axis_tdata[103:96];
    assign e_data = s_axis_tdata[119:104];

    logic [IW-1:0] ix_reg, iy_reg, iz_reg;
    logic [FB-1:0] u_reg [2:NS-1];
    logic [FB-1:0] v_reg [2:NS-2];
    logic [FB-1:0] w_reg [2:NS-3];
    logic [FB-1:0] u1_reg, v1_reg, w1_reg;
    logic [2:0]    psel;
    logic [IW-1:0] widx;
    logic [IW-1:0] widx_reg [3];
    logic [VW-1:0] wdat_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            ix_reg <= cx[FB +: IW];
            iy_reg <= cy[FB +: IW];
            iz_reg <= cz[FB +: IW];
            u1_reg <= cx[FB-1:0];
            v1_reg <= cy[FB-1:0];
            w1_reg <= cz[FB-1:0];
        end
    end

    // write strobes act on the accepted transfer directly
    always_comb begin
        psel = 3'b000;
        vwr  = 1'b0;
        if (s_axis_tvalid && en) begin
            unique case (s_axis_tuser)
                vnt3_pkg::OP_WR_VAL: vwr     = 1'b1;
                vnt3_pkg::OP_WR_PX:  psel[0] = 1'b1;
                vnt3_pkg::OP_WR_PY:  psel[1] = 1'b1;
                vnt3_pkg::OP_WR_PZ:  psel[2] = 1'b1;
                default: ;
            endcase
        end
    end
    assign widx = IW'(e_idx);

    // carry value writes down to the value table stage
    always_ff @(posedge aclk) begin
        if (en) begin
            widx_reg[0] <= widx;
            wdat_reg[0] <= e_data;
            for (int s = 1; s < 3; s++) begin
                widx_reg[s] <= widx_reg[s-1];
                wdat_reg[s] <= wdat_reg[s-1];
            end
        end
    end

    // stage 2: permutation reads
    logic [IW-1:0] px_reg [2], py_reg [2], pz_reg [2];
    vnt3_perm #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_perm (
        .aclk(aclk), .en(en), .wr_sel(psel), .wr_idx(widx),
        .wr_data(e_data[IW-1:0]),
        .ix(ix_reg), .iy(iy_reg), .iz(iz_reg),
        .px_reg(px_reg), .py_reg(py_reg), .pz_reg(pz_reg)
    );

    // fractions follow their stages
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[2] <= u1_reg;
            v_reg[2] <= v1_reg;
            w_reg[2] <= w1_reg;
            for (int s = 3; s <= NS-1; s++) u_reg[s] <= u_reg[s-1];
            for (int s = 3; s <= NS-2; s++) v_reg[s] <= v_reg[s-1];
            for (int s = 3; s <= NS-3; s++) w_reg[s] <= w_reg[s-1];
        end
    end

    // stage 3: corner keys, index = di*4 + dj*2 + dk
    logic [IW-1:0] key_reg [8];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 8; c++)
                key_reg[c] <= px_reg[c/4] ^ py_reg[(c/2)%2] ^ pz_reg[c%2];
        end
    end

    // stage 4: value table, one copy per corner read port
    logic [VW-1:0] val_reg [8];
    for (genvar g = 0; g < 8; g++) begin : g_val
        logic [VW-1:0] mem [TABLE_SIZE];
        always_ff @(posedge aclk) begin
            if (en && vwr_reg[2]) mem[widx_reg[2]] <= wdat_reg[2];
            if (en) val_reg[g] <= mem[key_reg[g]];
        end
    end

    // stage 5: blend along z
    logic [VW+FB-1:0] zs_reg [4];
    for (genvar g = 0; g < 4; g++) begin : g_lz
        vnt3_lerp #(.IN_W(VW), .FB(FB)) u_lz (
            .aclk(aclk), .en(en), .a(val_reg[2*g]), .b(val_reg[2*g+1]),
            .t(w_reg[NS-3]), .y_reg(zs_reg[g])
        );
    end

    // stage 6: blend along y
    logic [VW+2*FB-1:0] ys_reg [2];
    for (genvar g = 0; g < 2; g++) begin : g_ly
        vnt3_lerp #(.IN_W(VW+FB), .FB(FB)) u_ly (
            .aclk(aclk), .en(en), .a(zs_reg[2*g]), .b(zs_reg[2*g+1]),
            .t(v_reg[NS-2]), .y_reg(ys_reg[g])
        );
    end

    // stage 7: blend along x, truncate to the output width
    logic [VW+3*FB-1:0] xs_reg;
    vnt3_lerp #(.IN_W(VW+2*FB), .FB(FB)) u_lx (
        .aclk(aclk), .en(en), .a(ys_reg[0]), .b(ys_reg[1]),
        .t(u_reg[NS-1]), .y_reg(xs_reg)
    );
    assign m_axis_tdata = xs_reg[3*FB +: 16];
endmodule
`default_nettype wire
